// ----- hw/rtl/rprs_pkg.sv -----
`timescale 1ns / 1ps

package rprs_pkg;

	localparam int PULSE_W     = 12;
	localparam int TIME_W      = 32;
	localparam int MS_W        = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int MODE_W      = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_VALID_MIN       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VALID_MAX       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_WIDTH    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ARM_DEADBAND    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OFF_THRESHOLD   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_FAILSAFE_MS     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE_LOCKOUT_MS = 3'd7;

	localparam logic [PULSE_W-1:0] RST_VALID_MIN       = 12'd900;
	localparam logic [PULSE_W-1:0] RST_VALID_MAX       = 12'd2100;
	localparam logic [PULSE_W-1:0] RST_CENTER_WIDTH    = 12'd1500;
	localparam logic [PULSE_W-1:0] RST_ARM_DEADBAND    = 12'd100;
	localparam logic [PULSE_W-1:0] RST_ON_THRESHOLD    = 12'd1700;
	localparam logic [PULSE_W-1:0] RST_OFF_THRESHOLD   = 12'd1300;
	localparam logic [MS_W-1:0]    RST_FAILSAFE_MS     = 16'd500;
	localparam logic [MS_W-1:0]    RST_MODE_LOCKOUT_MS = 16'd200;

	localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MID  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_a;
		logic [PULSE_W-1:0] pulse_b;
		logic [PULSE_W-1:0] pulse_c;
		logic [TIME_W-1:0]  now_ms;
	} frame_t;

	typedef struct packed {
		logic relay_a;
		logic relay_b;
		logic relay_c;
		logic relay_d;
		logic armed;
		logic frame_valid;
	} result_t;

	typedef struct packed {
		logic [PULSE_W-1:0] valid_min;
		logic [PULSE_W-1:0] valid_max;
		logic [PULSE_W-1:0] center_width;
		logic [PULSE_W-1:0] arm_deadband;
		logic [PULSE_W-1:0] on_threshold;
		logic [PULSE_W-1:0] off_threshold;
		logic [MS_W-1:0]    failsafe_ms;
		logic [MS_W-1:0]    mode_lockout_ms;
	} cfg_t;

endpackage

// ----- hw/rtl/rprs_stream_if.sv -----
`timescale 1ns / 1ps

interface rprs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rc_pulse_relay_switch_unit.sv -----
`timescale 1ns / 1ps

// Relay switch driven by three RC servo channels.
// The frame channel carries one transaction per radio frame: three pulse widths
// in microseconds and a millisecond time stamp. The result channel returns one
// transaction per frame with the four relay drives, the armed flag and the
// frame validity. Thresholds and timeouts are set through the write port and
// should only be changed while no frame is in flight.
// A frame is captured in an input register and evaluated against the held state
// combinationally; its result is registered in the result register when that
// register is free or being taken, and is offered to the receiver from there.
// One frame is accepted every cycle while the receiver takes each result; the single
// compare and update pass over the input register sets that rate.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more frame; after that the frame channel
// deasserts ready until the result is taken.
// Reset returns every configuration register to its default, disarms control, clears the
// relays, sets the mode to middle and empties both registers.
module rc_pulse_relay_switch_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rprs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rprs_pkg::CFG_DATA_W-1:0]  cfg_data,
	rprs_stream_if.sink                      frame,
	rprs_stream_if.source                    result
);
	import rprs_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	frame_t  frame_s1;
	logic    out_valid_q;
	result_t out_data_q;
	result_t res;
	logic    advance;

	rprs_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rprs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.frame_s1 (frame_s1),
		.cfg      (cfg),
		.res      (res)
	);

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			frame_s1 <= frame.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_data_q;

endmodule

// ----- hw/rtl/rprs_cfg_regs.sv -----
`timescale 1ns / 1ps

module rprs_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rprs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rprs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output rprs_pkg::cfg_t                      cfg
);
	import rprs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valid_min       <= RST_VALID_MIN;
			cfg_q.valid_max       <= RST_VALID_MAX;
			cfg_q.center_width    <= RST_CENTER_WIDTH;
			cfg_q.arm_deadband    <= RST_ARM_DEADBAND;
			cfg_q.on_threshold    <= RST_ON_THRESHOLD;
			cfg_q.off_threshold   <= RST_OFF_THRESHOLD;
			cfg_q.failsafe_ms     <= RST_FAILSAFE_MS;
			cfg_q.mode_lockout_ms <= RST_MODE_LOCKOUT_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VALID_MIN:       cfg_q.valid_min       <= cfg_data[PULSE_W-1:0];
				REG_VALID_MAX:       cfg_q.valid_max       <= cfg_data[PULSE_W-1:0];
				REG_CENTER_WIDTH:    cfg_q.center_width    <= cfg_data[PULSE_W-1:0];
				REG_ARM_DEADBAND:    cfg_q.arm_deadband    <= cfg_data[PULSE_W-1:0];
				REG_ON_THRESHOLD:    cfg_q.on_threshold    <= cfg_data[PULSE_W-1:0];
				REG_OFF_THRESHOLD:   cfg_q.off_threshold   <= cfg_data[PULSE_W-1:0];
				REG_FAILSAFE_MS:     cfg_q.failsafe_ms     <= cfg_data[MS_W-1:0];
				REG_MODE_LOCKOUT_MS: cfg_q.mode_lockout_ms <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/rprs_core.sv -----
`timescale 1ns / 1ps

module rprs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  rprs_pkg::frame_t  frame_s1,
	input  rprs_pkg::cfg_t    cfg,
	output rprs_pkg::result_t res
);
	import rprs_pkg::*;

	logic                armed_q;
	logic [TIME_W-1:0]   last_valid_q;
	logic [3:0]          relay_q;
	logic [MODE_W-1:0]   mode_q;
	logic [TIME_W-1:0]   last_switch_q;

	logic                valid;
	logic [TIME_W-1:0]   last_valid_nxt;
	logic [TIME_W-1:0]   since_valid;
	logic [TIME_W-1:0]   since_switch;
	logic                armed_nxt;
	logic                any_off_center;
	logic [3:0]          relay_nxt;
	logic [MODE_W-1:0]   mode_sel;
	logic [MODE_W-1:0]   mode_nxt;
	logic [TIME_W-1:0]   last_switch_nxt;
	logic                take_switch;

	function automatic logic in_window(input logic [PULSE_W-1:0] w, input cfg_t c);
		return (w > c.valid_min) && (w < c.valid_max);
	endfunction

	function automatic logic off_center(input logic [PULSE_W-1:0] w, input cfg_t c);
		logic [PULSE_W-1:0] mag;
		mag = (w >= c.center_width) ? (w - c.center_width) : (c.center_width - w);
		return mag > c.arm_deadband;
	endfunction

	function automatic logic hyst(input logic [PULSE_W-1:0] w, input logic cur,
			input cfg_t c);
		logic r;
		if (w > c.on_threshold) r = 1'b1;
		else if (w < c.off_threshold) r = 1'b0;
		else r = cur;
		return r;
	endfunction

	always_comb begin
		valid = in_window(frame_s1.pulse_a, cfg) && in_window(frame_s1.pulse_b, cfg)
			&& in_window(frame_s1.pulse_c, cfg);
		last_valid_nxt = valid ? frame_s1.now_ms : last_valid_q;
		since_valid = frame_s1.now_ms - last_valid_nxt;
		any_off_center = off_center(frame_s1.pulse_a, cfg) || off_center(frame_s1.pulse_b, cfg)
			|| off_center(frame_s1.pulse_c, cfg);
		armed_nxt = (armed_q && (since_valid <= {{(TIME_W-MS_W){1'b0}}, cfg.failsafe_ms}))
			|| (valid && any_off_center);

		if (frame_s1.pulse_c < cfg.off_threshold) mode_sel = MODE_LOW;
		else if (frame_s1.pulse_c > cfg.on_threshold) mode_sel = MODE_HIGH;
		else mode_sel = MODE_MID;

		since_switch = frame_s1.now_ms - last_switch_q;
		take_switch = (mode_sel != mode_q)
			&& (since_switch > {{(TIME_W-MS_W){1'b0}}, cfg.mode_lockout_ms});

		relay_nxt = 4'b0000;
		mode_nxt = mode_q;
		last_switch_nxt = last_switch_q;
		if (valid && armed_nxt) begin
			relay_nxt[0] = hyst(frame_s1.pulse_a, relay_q[0], cfg);
			relay_nxt[1] = hyst(frame_s1.pulse_b, relay_q[1], cfg);
			relay_nxt[3:2] = relay_q[3:2];
			if (take_switch) begin
				relay_nxt[2] = (mode_sel == MODE_LOW);
				relay_nxt[3] = (mode_sel == MODE_HIGH);
				mode_nxt = mode_sel;
				last_switch_nxt = frame_s1.now_ms;
			end
		end

		res.relay_a = relay_nxt[0];
		res.relay_b = relay_nxt[1];
		res.relay_c = relay_nxt[2];
		res.relay_d = relay_nxt[3];
		res.armed = armed_nxt;
		res.frame_valid = valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			last_valid_q <= '0;
			relay_q <= '0;
			mode_q <= MODE_MID;
			last_switch_q <= '0;
		end else if (step_en) begin
			armed_q <= armed_nxt;
			last_valid_q <= last_valid_nxt;
			relay_q <= relay_nxt;
			mode_q <= mode_nxt;
			last_switch_q <= last_switch_nxt;
		end
	end

endmodule
